// ----- design/dq_pkg.sv -----
package dq_pkg;

    // Fixed payload widths
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 3;

    // Default number of slots in the ring store
    localparam int DEPTH_DEF = 32;

    // Request codes; the unused codes above ACT_LIST also list the contents
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_DROP_FRONT = 3'd2,
        ACT_DROP_REAR  = 3'd3,
        ACT_LIST       = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 3'd0,
        STS_UNDERFLOW = 3'd1,
        STS_OVERFLOW  = 3'd2,
        STS_ELEMENT   = 3'd3,
        STS_EMPTY     = 3'd4
    } t_status;

    // Control states of the top level
    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

endpackage

// ----- design/dq_req_if.sv -----
interface dq_req_if;
    import dq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);

endinterface

// ----- design/dq_res_if.sv -----
interface dq_res_if;
    import dq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic signed [DATA_W-1:0] element;
    logic                last;

    modport source (output valid, output status, output element, output last, input ready);
    modport sink   (input valid, input status, input element, input last, output ready);

endinterface

// ----- design/dq_ram.sv -----
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One registered read port; data holds while the read is not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/double_ended_queue_core.sv -----
// Double-ended queue of signed 32-bit values in a ring store of DEPTH slots (one
// synchronous RAM, head index and fill count in registers). Push front/rear and
// drop front/rear each return one status word (done, underflow on empty, overflow
// on full); a new request is taken every cycle while the result register is free
// or being drained. A listing returns every element front to rear, one word per
// cycle while the result register is free or being drained, the final one flagged
// last, or a single "empty" word; a listing holds off the next request until its
// final word is loaded, paced by the single read port of the RAM (one read in
// flight, data in the cycle after the read). Listings never change the contents.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dq_req_if.sink   i_req,
    dq_res_if.source o_res
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Control and pointer registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_lidx, n_lidx;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;

    // Result register
    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_element;
    logic              r_last;

    // RAM access
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Result load
    logic              out_free, out_load, req_acc;
    t_status           ld_status;
    logic [DATA_W-1:0] ld_element;
    logic              ld_last;

    // Derived pointer values
    logic              is_full, is_empty, is_last, list_req;
    logic [AW-1:0]     head_dec, head_inc, rear_addr, rd_next;
    logic [AW:0]       rear_sum;

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake
    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign req_acc     = i_req.valid && i_req.ready;

    // Ring arithmetic
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign is_last   = (r_lidx == r_count - CW'(1));
    assign list_req  = !(i_req.action inside {ACT_PUSH_FRONT, ACT_PUSH_REAR,
                                              ACT_DROP_FRONT, ACT_DROP_REAR});
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign rd_next   = (r_rd_addr == AW'(DEPTH - 1)) ? '0 : r_rd_addr + AW'(1);
    assign rear_sum  = {1'b0, r_head} + (AW + 1)'(r_count);
    assign rear_addr = (rear_sum >= (AW + 1)'(DEPTH)) ? AW'(rear_sum - (AW + 1)'(DEPTH))
                                                      : AW'(rear_sum);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && list_req && !is_empty) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free && is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control: pointer updates, RAM accesses, result load
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_lidx     = r_lidx;
        n_rd_addr  = r_rd_addr;
        ram_we     = 1'b0;
        ram_waddr  = rear_addr;
        ram_re     = 1'b0;
        ram_raddr  = r_head;
        out_load   = 1'b0;
        ld_status  = STS_DONE;
        ld_element = '0;
        ld_last    = 1'b1;
        if (req_acc) begin
            out_load = 1'b1;
            unique case (i_req.action)
                ACT_PUSH_FRONT: begin
                    if (is_full) begin
                        ld_status = STS_OVERFLOW;
                    end else begin
                        n_head    = head_dec;
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                        n_count   = r_count + CW'(1);
                    end
                end
                ACT_PUSH_REAR: begin
                    if (is_full) begin
                        ld_status = STS_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = rear_addr;
                        n_count   = r_count + CW'(1);
                    end
                end
                ACT_DROP_FRONT: begin
                    if (is_empty) begin
                        ld_status = STS_UNDERFLOW;
                    end else begin
                        n_head  = head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
                ACT_DROP_REAR: begin
                    if (is_empty) begin
                        ld_status = STS_UNDERFLOW;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    // Listing: report empty, or start the walk at the front
                    if (is_empty) begin
                        ld_status = STS_EMPTY;
                    end else begin
                        out_load  = 1'b0;
                        ram_re    = 1'b1;
                        ram_raddr = r_head;
                        n_rd_addr = r_head;
                        n_lidx    = '0;
                    end
                end
            endcase
        end else if (r_state == S_LIST && out_free) begin
            // Hand the word held at the RAM read port to the result register, read the next
            out_load   = 1'b1;
            ld_status  = STS_ELEMENT;
            ld_element = ram_rdata;
            ld_last    = is_last;
            if (!is_last) begin
                ram_re    = 1'b1;
                ram_raddr = rd_next;
                n_rd_addr = rd_next;
                n_lidx    = r_lidx + CW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk and result payload registers
    always_ff @(posedge i_clk) begin
        r_lidx    <= n_lidx;
        r_rd_addr <= n_rd_addr;
        if (out_load) begin
            r_status  <= ld_status;
            r_element <= ld_element;
            r_last    <= ld_last;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_status;
    assign o_res.element = r_element;
    assign o_res.last    = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_count != '0) && (r_lidx < r_count))
        else $error("walking an empty deque or past its end");

    a_list_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !i_req.ready)
        else $error("request taken during a listing");

    a_list_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> $stable(r_count) && $stable(r_head))
        else $error("pointers moved during a listing");

    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STS_ELEMENT) |-> (r_element == '0) && r_last)
        else $error("status word carries data or is not last");

endmodule

// ----- sim/dq_result_check.sv -----
`timescale 1ns / 100ps

module dq_result_check
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dq_req_if    i_req,
    dq_res_if    i_res,
    output int   o_errors,
    output int   o_outstanding
);

    // One result word as the deque should return it
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_result_word;

    t_result_word pending_words[$];

    // Shadow copy of the ring store
    logic signed [DATA_W-1:0] ring [DEPTH];
    int front_pos;
    int fill;
    int mismatch_total;

    function automatic void queue_word(input t_status s, input logic signed [DATA_W-1:0] e,
                                       input logic l);
        t_result_word w;
        w.status  = s;
        w.element = e;
        w.last    = l;
        pending_words.push_back(w);
    endfunction

    // Apply one request to the shadow deque and queue the words it should produce
    function automatic void apply_request(input logic [ACTION_W-1:0] act,
                                          input logic signed [DATA_W-1:0] val);
        case (act) inside
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (fill == DEPTH) begin
                    queue_word(STS_OVERFLOW, '0, 1'b1);
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        front_pos       = (front_pos + DEPTH - 1) % DEPTH;
                        ring[front_pos] = val;
                    end else begin
                        ring[(front_pos + fill) % DEPTH] = val;
                    end
                    fill++;
                    queue_word(STS_DONE, '0, 1'b1);
                end
            end
            ACT_DROP_FRONT, ACT_DROP_REAR: begin
                if (fill == 0) begin
                    queue_word(STS_UNDERFLOW, '0, 1'b1);
                end else begin
                    if (act == ACT_DROP_FRONT)
                        front_pos = (front_pos + 1) % DEPTH;
                    fill--;
                    queue_word(STS_DONE, '0, 1'b1);
                end
            end
            // listing, also reached by the unused codes
            default: begin
                if (fill == 0) begin
                    queue_word(STS_EMPTY, '0, 1'b1);
                end else begin
                    for (int k = 0; k < fill; k++)
                        queue_word(STS_ELEMENT, ring[(front_pos + k) % DEPTH], k == fill - 1);
                end
            end
        endcase
    endfunction

    function automatic void flag_error();
        mismatch_total++;
    endfunction

    // Track requests, then compare returned words against the oldest expectation
    always @(posedge i_clk) begin
        t_result_word want;
        if (!i_rst_n) begin
            front_pos = 0;
            fill      = 0;
            mismatch_total = 0;
            pending_words.delete();
        end else begin
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                apply_request(i_req.action, i_req.push_value);
            if ($isunknown(i_res.valid)) begin
                flag_error();
                if (mismatch_total <= 10)
                    $display("%0t: result valid is unknown", $realtime);
            end else if (i_res.valid && i_res.ready === 1'b1) begin
                if (pending_words.size() == 0) begin
                    flag_error();
                    if (mismatch_total <= 10)
                        $display("%0t: unrequested word: status=%0d element=%0d last=%0b",
                                 $realtime, i_res.status, i_res.element, i_res.last);
                end else begin
                    want = pending_words.pop_front();
                    if (i_res.status !== want.status || i_res.element !== want.element ||
                        i_res.last !== want.last) begin
                        flag_error();
                        if (mismatch_total <= 10)
                            $display({"%0t: mismatch: expected status=%0d element=%0d last=%0b,",
                                      " got status=%0d element=%0d last=%0b"}, $realtime,
                                     want.status, want.element, want.last,
                                     i_res.status, i_res.element, i_res.last);
                    end
                end
            end
        end
        o_errors      <= mismatch_total;
        o_outstanding <= pending_words.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import dq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int TIMEOUT_NS = 8_000_000;

    logic clk;
    logic rst_n;

    dq_req_if req_if ();
    dq_res_if res_if ();

    int errors;
    int outstanding;

    // Stimulus knobs and a rough fill level used to steer the random part
    int  idle_pct;
    int  stall_pct;
    int  level;
    int  overflow_hits;
    int  underflow_hits;
    bit  filling;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    dq_result_check #(
        .DEPTH(DEPTH)
    ) u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Receiver side: random back-pressure
    always @(posedge clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.push_value <= val;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
            if (level == DEPTH) overflow_hits++;
            else level++;
        end else if (act == ACT_DROP_FRONT || act == ACT_DROP_REAR) begin
            if (level == 0) underflow_hits++;
            else level--;
        end
        // swing between filling up and draining, hitting each end a few times
        if (filling && overflow_hits >= 3) begin
            filling        = 1'b0;
            underflow_hits = 0;
        end else if (!filling && underflow_hits >= 3) begin
            filling       = 1'b1;
            overflow_hits = 0;
        end
    endtask

    task automatic random_word();
        int roll;
        logic [ACTION_W-1:0] act;
        logic signed [DATA_W-1:0] val;
        logic [ACTION_W-1:0] push_act;
        logic [ACTION_W-1:0] drop_act;
        roll     = $urandom_range(99);
        push_act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        drop_act = $urandom_range(1) ? ACT_DROP_FRONT : ACT_DROP_REAR;
        if (roll < 8)
            act = ACITON_W_NOISE();
        else if (roll < 17)
            act = ACT_LIST;
        else if (roll < 20)
            act = 3'($urandom_range(7, 5));
        else if (roll < 88)
            act = filling ? push_act : drop_act;
        else
            act = filling ? drop_act : push_act;
        case ($urandom_range(15))
            0: val = 32'sh8000_0000;
            1: val = 32'sh7FFF_FFFF;
            2: val = '0;
            3: val = '1;
            default: val = $urandom;
        endcase
        send_word(act, val);
    endtask

    function automatic logic [ACTION_W-1:0] ACITON_W_NOISE();
        return 3'($urandom_range(7));
    endfunction

    // Directed opening: empty-deque corners, extreme values, unused codes, wrap
    task automatic directed_words();
        send_word(ACT_DROP_FRONT, 32'sd7);
        send_word(ACT_DROP_REAR, 32'sd7);
        send_word(ACT_LIST, '0);
        send_word(ACT_PUSH_FRONT, 32'sh8000_0000);
        send_word(ACT_PUSH_REAR, 32'sh7FFF_FFFF);
        send_word(ACT_PUSH_FRONT, '0);
        send_word(ACT_PUSH_REAR, '1);
        send_word(ACT_LIST, '0);
        send_word(3'd5, '0);
        send_word(3'd6, '1);
        send_word(3'd7, '0);
        send_word(ACT_DROP_FRONT, '0);
        send_word(ACT_DROP_REAR, '0);
        send_word(ACT_LIST, '0);
        send_word(ACT_DROP_FRONT, '0);
        send_word(ACT_DROP_REAR, '0);
        send_word(ACT_DROP_FRONT, '0);
        send_word(ACT_PUSH_REAR, 32'sh5555_5555);
        send_word(ACT_DROP_FRONT, '0);
        send_word(ACT_PUSH_FRONT, 32'shAAAA_AAAA);
        send_word(ACT_LIST, '0);
        send_word(ACT_DROP_REAR, '0);
        send_word(3'd7, '0);
    endtask

    // Main sequence: reset, four phases of varied idle and stall rates, drain, verdict
    initial begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_LIST;
        req_if.push_value = '0;
        idle_pct          = 0;
        stall_pct         = 0;
        level             = 0;
        overflow_hits     = 0;
        underflow_hits    = 0;
        filling           = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 76; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 76; end
                default: begin idle_pct = 15; stall_pct <= 15; end
            endcase
            if (phase == 0) directed_words();
            repeat (62) random_word();
        end
        req_if.valid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        stall_pct <= 0;
        repeat (64) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
